// File: sv/ctr_pkg.sv
// Shared types, sizes and codes for the sparse column-to-row transpose block.
package ctr_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int MAX_ENTRIES = 4096;
  localparam int NODE_W      = $clog2(MAX_NODES);
  localparam int NC_W        = NODE_W + 1;
  localparam int ENT_AW      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = ENT_AW + 1;
  localparam int WT_W        = 64;

  // Command codes.
  localparam logic [1:0] CMD_LOAD     = 2'd0;
  localparam logic [1:0] CMD_BUILD    = 2'd1;
  localparam logic [1:0] CMD_READ_EDG = 2'd2;
  localparam logic [1:0] CMD_READ_PTR = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_REV_MISS  = 3'd1;
  localparam logic [2:0] ST_REV_DROP  = 3'd2;
  localparam logic [2:0] ST_RANGE     = 3'd3;
  localparam logic [2:0] ST_ORDER     = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;
  localparam logic [2:0] ST_NOT_BUILT = 3'd6;

  // Configuration register indexes.
  localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [1:0] CFG_DROP_DIAG  = 2'd1;
  localparam logic [1:0] CFG_CHECK_REV  = 2'd2;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [NODE_W-1:0] column;
    logic [NODE_W-1:0] row;
    logic [WT_W-1:0]   weight_bits;
    logic [CNT_W-1:0]  index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [NODE_W-1:0] dest_node;
    logic [WT_W-1:0]   edge_weight;
    logic [ENT_AW-1:0] reverse_edge;
    logic              reverse_valid;
    logic [CNT_W-1:0]  count_value;
    logic [NODE_W-1:0] error_row;
    logic [NODE_W-1:0] error_col;
  } out_item_t;

endpackage

// File: sv/ctr_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module ctr_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/ctr_bsearch.sv
// Shared binary search step: midpoint, match and bound update.
module ctr_bsearch import ctr_pkg::*; (
  input  logic [CNT_W-1:0]  lo,
  input  logic [CNT_W-1:0]  hi,
  input  logic [ENT_AW-1:0] mid_in,
  input  logic [NODE_W-1:0] probe,
  input  logic [NODE_W-1:0] target,
  output logic [ENT_AW-1:0] mid,
  output logic              empty,
  output logic              found,
  output logic [CNT_W-1:0]  lo_nxt,
  output logic [CNT_W-1:0]  hi_nxt
);

  logic [CNT_W-1:0] span;
  logic [CNT_W-1:0] mid_full;

  // Midpoint of the half-open interval [lo, hi).
  always_comb begin
    span     = hi - lo;
    mid_full = lo + (span >> 1);
    mid      = mid_full[ENT_AW-1:0];
    empty    = (lo >= hi);
  end

  // Narrow the interval around the probed row.
  always_comb begin
    found  = (probe == target);
    lo_nxt = lo;
    hi_nxt = hi;
    if (probe < target) begin
      lo_nxt = {1'b0, mid_in} + CNT_W'(1);
    end else begin
      hi_nxt = {1'b0, mid_in};
    end
  end

endmodule

// File: sv/csc_to_csr_reverse_edges.sv
// Sparse column-to-row transpose: entry stores, build sequencer and result register.
// Load: check, record one column start per column opened, then store the entry.
// Build: clear row counters, count out-edges per row, prefix-sum into row pointers, place
// kept entries, then resolve each edge's reverse with the shared binary search step.
// One item is in work at a time; the next is taken once its result has been transferred.
// Reset (synchronous) clears control state only; stores are tracked by fill counts.
module csc_to_csr_reverse_edges import ctr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [NC_W-1:0]   cfg_data
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DISP     = 5'd1;
  localparam logic [4:0] S_LFILL    = 5'd2;
  localparam logic [4:0] S_LSTORE   = 5'd3;
  localparam logic [4:0] S_RD_E1    = 5'd4;
  localparam logic [4:0] S_RD_E2    = 5'd5;
  localparam logic [4:0] S_RD_E3    = 5'd6;
  localparam logic [4:0] S_RD_P1    = 5'd7;
  localparam logic [4:0] S_RD_P2    = 5'd8;
  localparam logic [4:0] S_B_CLR    = 5'd9;
  localparam logic [4:0] S_B_CNT_RD = 5'd10;
  localparam logic [4:0] S_B_CNT_CU = 5'd11;
  localparam logic [4:0] S_B_CNT_WR = 5'd12;
  localparam logic [4:0] S_B_PFX_RD = 5'd13;
  localparam logic [4:0] S_B_PFX_WR = 5'd14;
  localparam logic [4:0] S_B_PL_RD  = 5'd15;
  localparam logic [4:0] S_B_PL_CU  = 5'd16;
  localparam logic [4:0] S_B_PL_WR  = 5'd17;
  localparam logic [4:0] S_R_E2E    = 5'd18;
  localparam logic [4:0] S_R_SRC    = 5'd19;
  localparam logic [4:0] S_R_CHK    = 5'd20;
  localparam logic [4:0] S_R_LO     = 5'd21;
  localparam logic [4:0] S_R_HI     = 5'd22;
  localparam logic [4:0] S_R_MID    = 5'd23;
  localparam logic [4:0] S_R_CMP    = 5'd24;
  localparam logic [4:0] S_R_KEPT   = 5'd25;
  localparam logic [4:0] S_R_WR     = 5'd26;

  // Control registers.
  logic [4:0]        state_r, state_nxt;
  logic [NC_W-1:0]   node_count_r, node_count_nxt;
  logic              drop_r, drop_nxt;
  logic              check_r, check_nxt;
  logic [CNT_W-1:0]  entry_total_r, entry_total_nxt;
  logic [CNT_W-1:0]  edge_total_r, edge_total_nxt;
  logic              built_r, built_nxt;
  logic [NC_W-1:0]   cols_r, cols_nxt;
  logic              out_valid_r;

  // Work registers.
  in_item_t          item_r;
  logic [NODE_W-1:0] last_col_r, last_col_nxt;
  logic [NODE_W-1:0] last_row_r, last_row_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [CNT_W-1:0]  acc_r, acc_nxt;
  logic [NODE_W-1:0] r_r, r_nxt;
  logic [NODE_W-1:0] c_r, c_nxt;
  logic [ENT_AW-1:0] ent_r, ent_nxt;
  logic [NODE_W-1:0] dst_r, dst_nxt;
  logic [NODE_W-1:0] src_r, src_nxt;
  logic [CNT_W-1:0]  lo_r, lo_nxt;
  logic [CNT_W-1:0]  hi_r, hi_nxt;
  logic [ENT_AW-1:0] mid_r, mid_nxt;
  logic [ENT_AW-1:0] rent_r, rent_nxt;
  logic [2:0]        fail_r, fail_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  out_item_t         out_r;
  out_item_t         res;
  logic              fin;

  // Memory ports.
  logic                 er_we, ec_we, ew_we, cs_we, rp_we, cu_we;
  logic                 ed_we, ee_we, ex_we, kp_we, rv_we, ro_we;
  logic [ENT_AW-1:0]    er_waddr, er_raddr, ec_raddr, ew_waddr, ew_raddr;
  logic [NODE_W-1:0]    er_rdata, ec_rdata, cs_waddr, cs_raddr;
  logic [WT_W-1:0]      ew_rdata;
  logic [CNT_W-1:0]     cs_rdata, rp_rdata, rp_wdata, cu_rdata, cu_wdata;
  logic [NC_W-1:0]      rp_waddr, rp_raddr;
  logic [NODE_W-1:0]    cu_waddr, cu_raddr;
  logic [ENT_AW-1:0]    ed_waddr, ed_raddr, ee_waddr, ee_raddr, ee_rdata, ex_waddr;
  logic [ENT_AW-1:0]    ex_raddr, ex_rdata, kp_waddr, kp_raddr;
  logic [ENT_AW-1:0]    rv_waddr, rv_raddr, rv_wdata, rv_rdata, ro_waddr, ro_raddr;
  logic [NODE_W-1:0]    ed_rdata;
  logic                 kp_wdata, kp_rdata, ro_wdata, ro_rdata;

  // Shared search unit.
  logic [ENT_AW-1:0] bs_mid;
  logic              bs_empty, bs_found;
  logic [CNT_W-1:0]  bs_lo, bs_hi;
  logic [2:0]        rw_code;
  logic              accept;
  logic [NC_W-1:0]   cfg_nc;

  ctr_bsearch u_bsearch (
    .lo     (lo_r),
    .hi     (hi_r),
    .mid_in (mid_r),
    .probe  (er_rdata),
    .target (dst_r),
    .mid    (bs_mid),
    .empty  (bs_empty),
    .found  (bs_found),
    .lo_nxt (bs_lo),
    .hi_nxt (bs_hi)
  );

  ctr_ram #(.W(NODE_W), .D(MAX_ENTRIES)) u_ent_row (
    .clk(clk), .we(er_we), .waddr(er_waddr), .wdata(item_r.row),
    .raddr(er_raddr), .rdata(er_rdata));
  ctr_ram #(.W(NODE_W), .D(MAX_ENTRIES)) u_ent_col (
    .clk(clk), .we(ec_we), .waddr(er_waddr), .wdata(item_r.column),
    .raddr(ec_raddr), .rdata(ec_rdata));
  ctr_ram #(.W(WT_W), .D(MAX_ENTRIES)) u_ent_wt (
    .clk(clk), .we(ew_we), .waddr(ew_waddr), .wdata(item_r.weight_bits),
    .raddr(ew_raddr), .rdata(ew_rdata));
  ctr_ram #(.W(CNT_W), .D(MAX_NODES)) u_col_start (
    .clk(clk), .we(cs_we), .waddr(cs_waddr), .wdata(entry_total_r),
    .raddr(cs_raddr), .rdata(cs_rdata));
  ctr_ram #(.W(CNT_W), .D(MAX_NODES + 1)) u_row_ptr (
    .clk(clk), .we(rp_we), .waddr(rp_waddr), .wdata(rp_wdata),
    .raddr(rp_raddr), .rdata(rp_rdata));
  ctr_ram #(.W(CNT_W), .D(MAX_NODES)) u_cursor (
    .clk(clk), .we(cu_we), .waddr(cu_waddr), .wdata(cu_wdata),
    .raddr(cu_raddr), .rdata(cu_rdata));
  ctr_ram #(.W(NODE_W), .D(MAX_ENTRIES)) u_edge_dest (
    .clk(clk), .we(ed_we), .waddr(ed_waddr), .wdata(c_r),
    .raddr(ed_raddr), .rdata(ed_rdata));
  ctr_ram #(.W(ENT_AW), .D(MAX_ENTRIES)) u_edge_ent (
    .clk(clk), .we(ee_we), .waddr(ee_waddr), .wdata(k_r[ENT_AW-1:0]),
    .raddr(ee_raddr), .rdata(ee_rdata));
  ctr_ram #(.W(ENT_AW), .D(MAX_ENTRIES)) u_ent_edge (
    .clk(clk), .we(ex_we), .waddr(ex_waddr), .wdata(cu_rdata[ENT_AW-1:0]),
    .raddr(ex_raddr), .rdata(ex_rdata));
  ctr_ram #(.W(1), .D(MAX_ENTRIES)) u_kept (
    .clk(clk), .we(kp_we), .waddr(kp_waddr), .wdata(kp_wdata),
    .raddr(kp_raddr), .rdata(kp_rdata));
  ctr_ram #(.W(ENT_AW), .D(MAX_ENTRIES)) u_rev (
    .clk(clk), .we(rv_we), .waddr(rv_waddr), .wdata(rv_wdata),
    .raddr(rv_raddr), .rdata(rv_rdata));
  ctr_ram #(.W(1), .D(MAX_ENTRIES)) u_rev_ok (
    .clk(clk), .we(ro_we), .waddr(ro_waddr), .wdata(ro_wdata),
    .raddr(ro_raddr), .rdata(ro_rdata));

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Outcome of one reverse lookup.
  always_comb begin
    if (fail_r != ST_OK) begin
      rw_code = fail_r;
    end else if (!kp_rdata) begin
      rw_code = ST_REV_DROP;
    end else begin
      rw_code = ST_OK;
    end
  end

  // Clamped node count from a configuration write.
  always_comb begin
    cfg_nc = cfg_data;
    if (cfg_nc == '0) begin
      cfg_nc = NC_W'(1);
    end else if (cfg_nc > NC_W'(MAX_NODES)) begin
      cfg_nc = NC_W'(MAX_NODES);
    end
  end

  // Memory port selection per sequencer state.
  always_comb begin
    er_we = 1'b0; ec_we = 1'b0; ew_we = 1'b0; cs_we = 1'b0; rp_we = 1'b0;
    cu_we = 1'b0; ed_we = 1'b0; ee_we = 1'b0; ex_we = 1'b0; kp_we = 1'b0;
    rv_we = 1'b0; ro_we = 1'b0;
    er_waddr = entry_total_r[ENT_AW-1:0];
    ew_waddr = entry_total_r[ENT_AW-1:0];
    er_raddr = k_r[ENT_AW-1:0];
    ec_raddr = k_r[ENT_AW-1:0];
    ew_raddr = ee_rdata;
    cs_waddr = cols_r[NODE_W-1:0];
    cs_raddr = src_r;
    rp_waddr = k_r[NC_W-1:0] + NC_W'(1);
    rp_wdata = acc_r + cu_rdata;
    rp_raddr = item_r.index[NC_W-1:0];
    cu_waddr = r_r;
    cu_wdata = cu_rdata + CNT_W'(1);
    cu_raddr = k_r[NODE_W-1:0];
    ed_waddr = cu_rdata[ENT_AW-1:0];
    ed_raddr = k_r[ENT_AW-1:0];
    ee_waddr = cu_rdata[ENT_AW-1:0];
    ee_raddr = k_r[ENT_AW-1:0];
    ex_waddr = k_r[ENT_AW-1:0];
    ex_raddr = rent_r;
    kp_waddr = k_r[ENT_AW-1:0];
    kp_wdata = 1'b1;
    kp_raddr = rent_r;
    rv_waddr = k_r[ENT_AW-1:0];
    rv_wdata = (rw_code == ST_OK) ? ex_rdata : '0;
    rv_raddr = item_r.index[ENT_AW-1:0];
    ro_waddr = k_r[ENT_AW-1:0];
    ro_wdata = (rw_code == ST_OK);
    ro_raddr = item_r.index[ENT_AW-1:0];
    case (state_r)
      S_LFILL: begin
        cs_we = ({1'b0, item_r.column} >= cols_r);
      end
      S_LSTORE: begin
        er_we = 1'b1;
        ec_we = 1'b1;
        ew_we = 1'b1;
      end
      S_RD_E1: begin
        ed_raddr = item_r.index[ENT_AW-1:0];
        ee_raddr = item_r.index[ENT_AW-1:0];
      end
      S_B_CLR: begin
        cu_we    = 1'b1;
        cu_waddr = k_r[NODE_W-1:0];
        cu_wdata = '0;
        rp_we    = (k_r == '0);
        rp_waddr = '0;
        rp_wdata = '0;
      end
      S_B_CNT_CU: begin
        cu_raddr = er_rdata;
      end
      S_B_CNT_WR: begin
        cu_we = 1'b1;
      end
      S_B_PFX_WR: begin
        rp_we    = 1'b1;
        cu_we    = 1'b1;
        cu_waddr = k_r[NODE_W-1:0];
        cu_wdata = acc_r;
      end
      S_B_PL_CU: begin
        cu_raddr = er_rdata;
        kp_we    = drop_r && (er_rdata == ec_rdata);
        kp_wdata = 1'b0;
      end
      S_B_PL_WR: begin
        cu_we = 1'b1;
        ed_we = 1'b1;
        ee_we = 1'b1;
        ex_we = 1'b1;
        kp_we = 1'b1;
      end
      S_R_SRC: begin
        er_raddr = ee_rdata;
      end
      S_R_CHK: begin
        cs_raddr = er_rdata;
      end
      S_R_LO: begin
        cs_raddr = src_r + NODE_W'(1);
      end
      S_R_MID: begin
        er_raddr = bs_mid;
      end
      S_R_WR: begin
        rv_we = !((rw_code != ST_OK) && check_r);
        ro_we = rv_we;
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt       = state_r;
    node_count_nxt  = node_count_r;
    drop_nxt        = drop_r;
    check_nxt       = check_r;
    entry_total_nxt = entry_total_r;
    edge_total_nxt  = edge_total_r;
    built_nxt       = built_r;
    cols_nxt        = cols_r;
    last_col_nxt    = last_col_r;
    last_row_nxt    = last_row_r;
    k_nxt           = k_r;
    acc_nxt         = acc_r;
    r_nxt           = r_r;
    c_nxt           = c_r;
    ent_nxt         = ent_r;
    dst_nxt         = dst_r;
    src_nxt         = src_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    mid_nxt         = mid_r;
    rent_nxt        = rent_r;
    fail_nxt        = fail_r;
    rd_ok_nxt       = rd_ok_r;
    res             = '0;
    fin             = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (item_r.cmd)
          CMD_LOAD: begin
            if ({1'b0, item_r.column} >= node_count_r ||
                {1'b0, item_r.row} >= node_count_r) begin
              res.status = ST_RANGE;
              fin        = 1'b1;
            end else if (entry_total_r != '0 && (item_r.column < last_col_r ||
                         (item_r.column == last_col_r && item_r.row <= last_row_r))) begin
              res.status = ST_ORDER;
              fin        = 1'b1;
            end else if (entry_total_r >= CNT_W'(MAX_ENTRIES)) begin
              res.status = ST_FULL;
              fin        = 1'b1;
            end else begin
              state_nxt = S_LFILL;
            end
          end
          CMD_BUILD: begin
            built_nxt = 1'b0;
            k_nxt     = '0;
            state_nxt = S_B_CLR;
          end
          CMD_READ_EDG: begin
            if (!built_r) begin
              res.status = ST_NOT_BUILT;
              fin        = 1'b1;
            end else if (item_r.index >= edge_total_r) begin
              res.status = ST_RANGE;
              fin        = 1'b1;
            end else begin
              state_nxt = S_RD_E1;
            end
          end
          default: begin
            if (!built_r) begin
              res.status = ST_NOT_BUILT;
              fin        = 1'b1;
            end else if (item_r.index > CNT_W'(node_count_r)) begin
              res.status = ST_RANGE;
              fin        = 1'b1;
            end else begin
              state_nxt = S_RD_P1;
            end
          end
        endcase
      end
      // Record start of every column opened by this load, one per cycle.
      S_LFILL: begin
        if ({1'b0, item_r.column} >= cols_r) begin
          cols_nxt = cols_r + NC_W'(1);
        end else begin
          state_nxt = S_LSTORE;
        end
      end
      S_LSTORE: begin
        entry_total_nxt   = entry_total_r + CNT_W'(1);
        last_col_nxt      = item_r.column;
        last_row_nxt      = item_r.row;
        built_nxt         = 1'b0;
        res.count_value   = entry_total_r + CNT_W'(1);
        fin               = 1'b1;
      end
      S_RD_E1: begin
        state_nxt = S_RD_E2;
      end
      S_RD_E2: begin
        dst_nxt   = ed_rdata;
        mid_nxt   = rv_rdata;
        rd_ok_nxt = ro_rdata;
        state_nxt = S_RD_E3;
      end
      S_RD_E3: begin
        res.dest_node     = dst_r;
        res.edge_weight   = ew_rdata;
        res.reverse_edge  = mid_r;
        res.reverse_valid = rd_ok_r;
        fin               = 1'b1;
      end
      S_RD_P1: begin
        state_nxt = S_RD_P2;
      end
      S_RD_P2: begin
        res.count_value = rp_rdata;
        fin             = 1'b1;
      end
      // Zero the per-row counters.
      S_B_CLR: begin
        if (k_r == CNT_W'(node_count_r) - CNT_W'(1)) begin
          k_nxt     = '0;
          state_nxt = S_B_CNT_RD;
        end else begin
          k_nxt = k_r + CNT_W'(1);
        end
      end
      // Count out-edges per source row.
      S_B_CNT_RD: begin
        if (k_r == entry_total_r) begin
          k_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = S_B_PFX_RD;
        end else begin
          state_nxt = S_B_CNT_CU;
        end
      end
      S_B_CNT_CU: begin
        r_nxt = er_rdata;
        if (drop_r && er_rdata == ec_rdata) begin
          k_nxt     = k_r + CNT_W'(1);
          state_nxt = S_B_CNT_RD;
        end else begin
          state_nxt = S_B_CNT_WR;
        end
      end
      S_B_CNT_WR: begin
        k_nxt     = k_r + CNT_W'(1);
        state_nxt = S_B_CNT_RD;
      end
      // Running sum into row pointers and write cursors.
      S_B_PFX_RD: begin
        if (k_r == CNT_W'(node_count_r)) begin
          edge_total_nxt = acc_r;
          k_nxt          = '0;
          state_nxt      = S_B_PL_RD;
        end else begin
          state_nxt = S_B_PFX_WR;
        end
      end
      S_B_PFX_WR: begin
        acc_nxt   = acc_r + cu_rdata;
        k_nxt     = k_r + CNT_W'(1);
        state_nxt = S_B_PFX_RD;
      end
      // Place every kept entry at its row's cursor.
      S_B_PL_RD: begin
        if (k_r == entry_total_r) begin
          if (edge_total_r == '0) begin
            built_nxt = 1'b1;
            fin       = 1'b1;
          end else begin
            k_nxt     = '0;
            state_nxt = S_R_E2E;
          end
        end else begin
          state_nxt = S_B_PL_CU;
        end
      end
      S_B_PL_CU: begin
        r_nxt = er_rdata;
        c_nxt = ec_rdata;
        if (drop_r && er_rdata == ec_rdata) begin
          k_nxt     = k_r + CNT_W'(1);
          state_nxt = S_B_PL_RD;
        end else begin
          state_nxt = S_B_PL_WR;
        end
      end
      S_B_PL_WR: begin
        k_nxt     = k_r + CNT_W'(1);
        state_nxt = S_B_PL_RD;
      end
      // Reverse edge search, one edge at a time.
      S_R_E2E: begin
        fail_nxt  = ST_OK;
        state_nxt = S_R_SRC;
      end
      S_R_SRC: begin
        ent_nxt   = ee_rdata;
        dst_nxt   = ed_rdata;
        state_nxt = S_R_CHK;
      end
      S_R_CHK: begin
        src_nxt = er_rdata;
        if (!drop_r && er_rdata == dst_r) begin
          rent_nxt  = ent_r;
          state_nxt = S_R_KEPT;
        end else begin
          state_nxt = S_R_LO;
        end
      end
      S_R_LO: begin
        lo_nxt    = ({1'b0, src_r} < cols_r) ? cs_rdata : entry_total_r;
        state_nxt = S_R_HI;
      end
      S_R_HI: begin
        hi_nxt    = (({1'b0, src_r} + NC_W'(1)) < cols_r) ? cs_rdata : entry_total_r;
        state_nxt = S_R_MID;
      end
      S_R_MID: begin
        if (bs_empty) begin
          fail_nxt  = ST_REV_MISS;
          state_nxt = S_R_WR;
        end else begin
          mid_nxt   = bs_mid;
          state_nxt = S_R_CMP;
        end
      end
      S_R_CMP: begin
        if (bs_found) begin
          rent_nxt  = mid_r;
          state_nxt = S_R_KEPT;
        end else begin
          lo_nxt    = bs_lo;
          hi_nxt    = bs_hi;
          state_nxt = S_R_MID;
        end
      end
      S_R_KEPT: begin
        state_nxt = S_R_WR;
      end
      S_R_WR: begin
        if (rw_code != ST_OK && check_r) begin
          res.status    = rw_code;
          res.error_row = src_r;
          res.error_col = dst_r;
          fin           = 1'b1;
        end else if (k_r + CNT_W'(1) == edge_total_r) begin
          built_nxt       = 1'b1;
          res.count_value = edge_total_r;
          fin             = 1'b1;
        end else begin
          k_nxt     = k_r + CNT_W'(1);
          state_nxt = S_R_E2E;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (fin) begin
      state_nxt = S_IDLE;
    end

    // Configuration writes must arrive only while idle; the block itself does not enforce it.
    if (cfg_we) begin
      case (cfg_index)
        CFG_NODE_COUNT: begin
          node_count_nxt  = cfg_nc;
          entry_total_nxt = '0;
          edge_total_nxt  = '0;
          cols_nxt        = '0;
          built_nxt       = 1'b0;
        end
        CFG_DROP_DIAG: begin
          drop_nxt  = cfg_data[0];
          built_nxt = 1'b0;
        end
        CFG_CHECK_REV: begin
          check_nxt = cfg_data[0];
          built_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      node_count_r  <= NC_W'(1);
      drop_r        <= 1'b1;
      check_r       <= 1'b1;
      entry_total_r <= '0;
      edge_total_r  <= '0;
      built_r       <= 1'b0;
      cols_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      node_count_r  <= node_count_nxt;
      drop_r        <= drop_nxt;
      check_r       <= check_nxt;
      entry_total_r <= entry_total_nxt;
      edge_total_r  <= edge_total_nxt;
      built_r       <= built_nxt;
      cols_r        <= cols_nxt;
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Work registers and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (fin) begin
      out_r <= res;
    end
    last_col_r <= last_col_nxt;
    last_row_r <= last_row_nxt;
    k_r        <= k_nxt;
    acc_r      <= acc_nxt;
    r_r        <= r_nxt;
    c_r        <= c_nxt;
    ent_r      <= ent_nxt;
    dst_r      <= dst_nxt;
    src_r      <= src_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    rent_r     <= rent_nxt;
    fail_r     <= fail_nxt;
    rd_ok_r    <= rd_ok_nxt;
  end

  // A built graph never holds more edges than loaded entries.
  assert property (@(posedge clk) disable iff (!rst_n)
    built_r |-> (edge_total_r <= entry_total_r))
    else $error("edge total exceeds entry total");

  // Opened columns never pass the node count.
  assert property (@(posedge clk) disable iff (!rst_n)
    cols_r <= node_count_r)
    else $error("column starts beyond node count");

  // An accepted transfer always starts work.
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("accepted item not dispatched");

  // The entry count stays within the store.
  assert property (@(posedge clk) disable iff (!rst_n)
    entry_total_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count overflow");

endmodule

// File: sim/csc_to_csr_reverse_edges_tb.sv
// Testbench for the sparse column-to-row transpose block with reverse-edge lookup.
`timescale 1ns / 100ps

module csc_to_csr_reverse_edges_tb;
  import ctr_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 4000000;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  in_item_t        in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  out_item_t       out_data;
  logic            cfg_we = 1'b0;
  logic [1:0]      cfg_index = '0;
  logic [NC_W-1:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int error_count = 0;
  int items_sent = 0;

  out_item_t expected_results[$];

  // Shadow copy of the transpose state.
  int unsigned nodes_q, drop_diag_q, check_rev_q;
  bit [9:0]    ent_row[MAX_ENTRIES];
  bit [63:0]   ent_wt[MAX_ENTRIES];
  int unsigned col_start[MAX_NODES+1];
  int unsigned row_ptr[MAX_NODES+1];
  int unsigned cursor[MAX_NODES];
  bit [9:0]    edge_dest[MAX_ENTRIES];
  int unsigned edge_ent[MAX_ENTRIES];
  int unsigned ent_edge[MAX_ENTRIES];
  bit          ent_kept[MAX_ENTRIES];
  int unsigned rev_idx[MAX_ENTRIES];
  bit          rev_ok[MAX_ENTRIES];
  int unsigned n_entries, n_edges, cols_open;
  bit          built;

  csc_to_csr_reverse_edges dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver stall: a long hold-off when requested, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic void clear_entries();
    for (int i = 0; i <= MAX_NODES; i++) col_start[i] = 0;
    n_entries = 0;
    n_edges = 0;
    cols_open = 0;
    built = 0;
  endfunction

  function automatic int unsigned col_ptr(int unsigned c);
    if (c < cols_open && c <= MAX_NODES) return col_start[c];
    return n_entries;
  endfunction

  function automatic bit find_entry(int unsigned c, int unsigned target,
                                    output int unsigned pos);
    int unsigned lo, hi, mid, v;
    lo = col_ptr(c);
    hi = col_ptr(c + 1);
    pos = 0;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      v = 32'(ent_row[mid]);
      if (v == target) begin
        pos = mid;
        return 1'b1;
      end
      if (v < target) lo = mid + 1;
      else hi = mid;
    end
    return 1'b0;
  endfunction

  function automatic void apply_config(logic [1:0] idx, int unsigned val);
    int unsigned v;
    v = val & 32'h7FF;
    if (idx == CFG_NODE_COUNT) begin
      if (v < 1) v = 1;
      if (v > MAX_NODES) v = MAX_NODES;
      nodes_q = v;
      clear_entries();
    end else if (idx == CFG_DROP_DIAG) begin
      drop_diag_q = val & 1;
      built = 0;
    end else if (idx == CFG_CHECK_REV) begin
      check_rev_q = val & 1;
      built = 0;
    end
  endfunction

  // Graph build: count, prefix-sum, place by source row, then resolve reverses.
  function automatic void build_transpose(ref out_item_t r);
    int unsigned n, rw, e, ent, dst, src, rent, fail;
    n = nodes_q;
    built = 0;
    for (int i = 0; i < n; i++) cursor[i] = 0;
    for (int c = 0; c < n; c++)
      for (int unsigned k = col_ptr(c); k < col_ptr(c + 1); k++) begin
        rw = 32'(ent_row[k]);
        if (drop_diag_q && rw == c) continue;
        if (rw < n) cursor[rw]++;
      end
    row_ptr[0] = 0;
    for (int i = 0; i < n; i++) begin
      row_ptr[i+1] = row_ptr[i] + cursor[i];
      cursor[i] = row_ptr[i];
    end
    n_edges = row_ptr[n];
    for (int c = 0; c < n; c++)
      for (int unsigned k = col_ptr(c); k < col_ptr(c + 1); k++) begin
        rw = 32'(ent_row[k]);
        ent_kept[k] = 0;
        if ((drop_diag_q && rw == c) || rw >= n) continue;
        e = cursor[rw]++;
        edge_dest[e] = NODE_W'(c);
        edge_ent[e] = k;
        ent_edge[k] = e;
        ent_kept[k] = 1;
      end
    for (e = 0; e < n_edges; e++) begin
      ent = edge_ent[e];
      dst = 32'(edge_dest[e]);
      src = 32'(ent_row[ent]);
      rent = 0;
      fail = 0;
      if (!drop_diag_q && src == dst) rent = ent;
      else if (!find_entry(src, dst, rent)) fail = 1;
      if (fail == 0 && !ent_kept[rent]) fail = 2;
      if (fail != 0) begin
        if (check_rev_q) begin
          r.status = (fail == 1) ? ST_REV_MISS : ST_REV_DROP;
          r.error_row = NODE_W'(src);
          r.error_col = NODE_W'(dst);
          return;
        end
        rev_idx[e] = 0;
        rev_ok[e] = 0;
      end else begin
        rev_idx[e] = ent_edge[rent];
        rev_ok[e] = 1;
      end
    end
    built = 1;
    r.status = ST_OK;
    r.count_value = CNT_W'(n_edges);
  endfunction

  // Expected result of one accepted command, updating the shadow state.
  function automatic out_item_t transpose_predict(in_item_t it);
    out_item_t r;
    int unsigned c, rw, idx, lastc;
    r = '0;
    c = 32'(it.column);
    rw = 32'(it.row);
    idx = 32'(it.index);
    if (it.cmd == CMD_LOAD) begin
      if (c >= nodes_q || rw >= nodes_q) begin
        r.status = ST_RANGE;
      end else if (n_entries > 0 && (c < cols_open - 1 ||
                   (c == cols_open - 1 && rw <= 32'(ent_row[n_entries-1])))) begin
        r.status = ST_ORDER;
      end else if (n_entries >= MAX_ENTRIES) begin
        r.status = ST_FULL;
      end else begin
        while (cols_open <= c) begin
          col_start[cols_open] = n_entries;
          cols_open++;
        end
        ent_row[n_entries] = NODE_W'(rw);
        ent_wt[n_entries] = it.weight_bits;
        n_entries++;
        built = 0;
        r.status = ST_OK;
        r.count_value = CNT_W'(n_entries);
      end
    end else if (it.cmd == CMD_BUILD) begin
      build_transpose(r);
    end else if (!built) begin
      r.status = ST_NOT_BUILT;
    end else if (it.cmd == CMD_READ_EDG) begin
      if (idx >= n_edges || idx >= MAX_ENTRIES) begin
        r.status = ST_RANGE;
      end else begin
        r.dest_node = edge_dest[idx];
        r.edge_weight = ent_wt[edge_ent[idx] % MAX_ENTRIES];
        r.reverse_edge = ENT_AW'(rev_idx[idx]);
        r.reverse_valid = rev_ok[idx];
      end
    end else begin
      if (idx > nodes_q || idx > MAX_NODES) r.status = ST_RANGE;
      else r.count_value = CNT_W'(row_ptr[idx]);
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // Result checker: each transfer is compared with the oldest expectation.
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, out_data);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("status", 64'(exp_r.status), 64'(out_data.status));
        check_field("dest_node", 64'(exp_r.dest_node), 64'(out_data.dest_node));
        check_field("edge_weight", exp_r.edge_weight, out_data.edge_weight);
        check_field("reverse_edge", 64'(exp_r.reverse_edge), 64'(out_data.reverse_edge));
        check_field("reverse_valid", 64'(exp_r.reverse_valid),
                    64'(out_data.reverse_valid));
        check_field("count_value", 64'(exp_r.count_value), 64'(out_data.count_value));
        check_field("error_row", 64'(exp_r.error_row), 64'(out_data.error_row));
        check_field("error_col", 64'(exp_r.error_col), 64'(out_data.error_col));
      end
    end
  end

  // One input transfer; the expectation is formed when the block takes it.
  task automatic send_item(in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(transpose_predict(it));
    items_sent++;
  endtask

  function automatic in_item_t make_item(logic [1:0] cmd, int unsigned c, int unsigned rw,
                                         logic [63:0] w, int unsigned idx);
    in_item_t it;
    it.cmd = cmd;
    it.column = NODE_W'(c);
    it.row = NODE_W'(rw);
    it.weight_bits = w;
    it.index = CNT_W'(idx);
    return it;
  endfunction

  function automatic logic [63:0] rand_weight();
    return {$urandom, $urandom};
  endfunction

  task automatic load_entry(int unsigned c, int unsigned rw, logic [63:0] w);
    send_item(make_item(CMD_LOAD, c, rw, w, $urandom_range(8191)));
  endtask

  task automatic issue(logic [1:0] cmd, int unsigned idx);
    send_item(make_item(cmd, $urandom_range(1023), $urandom_range(1023), rand_weight(), idx));
  endtask

  // Wait until every expected result has been transferred.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, int unsigned val);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= NC_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    apply_config(idx, val);
  endtask

  task automatic set_graph_mode(int unsigned n, int unsigned dd, int unsigned cr);
    cfg_write(CFG_NODE_COUNT, n);
    cfg_write(CFG_DROP_DIAG, dd);
    cfg_write(CFG_CHECK_REV, cr);
  endtask

  // Reads before any build, an empty build and range limits at reset settings.
  task automatic test_after_reset();
    issue(CMD_READ_EDG, 0);
    issue(CMD_READ_PTR, 0);
    issue(CMD_BUILD, 0);
    issue(CMD_READ_EDG, 0);
    issue(CMD_READ_PTR, 1);
    issue(CMD_READ_PTR, 2);
    issue(CMD_READ_PTR, 8191);
  endtask

  // Load checks, build error, unchecked reverses and register side effects.
  task automatic test_load_and_build();
    set_graph_mode(8, 0, 1);
    load_entry(8, 0, '0);
    load_entry(0, 1023, '1);
    load_entry(0, 0, '0);
    load_entry(0, 3, '1);
    load_entry(0, 3, rand_weight());
    load_entry(1, 5, rand_weight());
    load_entry(0, 7, rand_weight());
    load_entry(3, 0, rand_weight());
    issue(CMD_BUILD, 0);
    issue(CMD_READ_EDG, 0);
    cfg_write(CFG_CHECK_REV, 0);
    issue(CMD_BUILD, 0);
    for (int i = 0; i < 5; i++) issue(CMD_READ_EDG, i);
    issue(CMD_READ_PTR, 8);
    issue(CMD_READ_PTR, 9);
    cfg_write(CFG_UNUSED, 2047);
    issue(CMD_READ_PTR, 3);
    load_entry(7, 7, rand_weight());
    issue(CMD_READ_EDG, 0);
    cfg_write(CFG_NODE_COUNT, 0);
    issue(CMD_READ_EDG, 0);
    load_entry(0, 0, rand_weight());
    issue(CMD_BUILD, 0);
  endtask

  // Corner nodes of the largest matrix.
  task automatic test_extreme_nodes();
    set_graph_mode(2047, 0, 1);
    load_entry(0, 0, '1);
    load_entry(0, 1023, rand_weight());
    load_entry(1023, 0, rand_weight());
    load_entry(1023, 1023, '0);
    issue(CMD_BUILD, 0);
    for (int i = 0; i < 4; i++) issue(CMD_READ_EDG, i);
    issue(CMD_READ_EDG, 4096);
    issue(CMD_READ_PTR, 1024);
    issue(CMD_READ_PTR, 1025);
  endtask

  // A dense block in the largest matrix, a repeated entry, and the build.
  task automatic test_dense_block();
    set_graph_mode(1024, 1, 1);
    for (int c = 0; c < 16; c++)
      for (int rw = 0; rw < 16; rw++) load_entry(c, rw, rand_weight());
    load_entry(15, 15, rand_weight());
    issue(CMD_BUILD, 0);
    issue(CMD_READ_EDG, n_edges - 1);
    issue(CMD_READ_PTR, 16);
  endtask

  // Receiver holds off while commands keep coming, so the input backs up.
  task automatic test_backpressure();
    set_graph_mode(4, 1, 0);
    hold_left = 300;
    for (int i = 0; i < 20; i++) issue(CMD_READ_PTR, $urandom_range(5));
    drain();
  endtask

  // Random well-formed matrices with some noise, each followed by build and reads.
  task automatic random_round();
    bit adj[16][16];
    int unsigned n, dens;
    logic [127:0] noise;
    in_item_t it;
    n = $urandom_range(1, 16);
    dens = $urandom_range(10, 70);
    set_graph_mode(n, $urandom_range(1), $urandom_range(1));
    for (int c = 0; c < n; c++)
      for (int rw = c; rw < n; rw++) begin
        adj[c][rw] = ($urandom_range(99) < dens);
        adj[rw][c] = ($urandom_range(99) < 85) ? adj[c][rw] : 1'($urandom_range(1));
      end
    for (int c = 0; c < n; c++)
      for (int rw = 0; rw < n; rw++) begin
        if ($urandom_range(99) < 4) begin
          noise = {$urandom, $urandom, $urandom, $urandom};
          it = noise[$bits(in_item_t)-1:0];
          send_item(it);
        end
        if (adj[c][rw]) load_entry(c, rw, rand_weight());
      end
    issue(CMD_BUILD, 0);
    repeat ($urandom_range(4, 14)) begin
      case ($urandom_range(9))
        0: issue(CMD_READ_EDG, $urandom_range(8191));
        1, 2, 3: issue(CMD_READ_PTR, $urandom_range(n + 1));
        default: issue(CMD_READ_EDG, $urandom_range(n_edges));
      endcase
    end
  endtask

  task automatic test_random(int idle_pct, int stall_pct);
    int target;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    target = items_sent + 270;
    while (items_sent < target) random_round();
    drain();
  endtask

  initial begin
    nodes_q = 1;
    drop_diag_q = 1;
    check_rev_q = 1;
    clear_entries();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_load_and_build();
    test_extreme_nodes();
    test_dense_block();
    test_backpressure();
    test_random(0, 0);
    test_random(47, 0);
    test_random(0, 47);
    test_random(25, 25);

    drain();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
sv/ctr_pkg.sv
sv/ctr_ram.sv
sv/ctr_bsearch.sv
sv/csc_to_csr_reverse_edges.sv
sim/csc_to_csr_reverse_edges_tb.sv
